// ===== hdl/mvcs_pkg.sv =====
package mvcs_pkg;

  localparam int WinBytes = 8;
  localparam int CfgIdxW  = 2;

  typedef enum logic [1:0] {
    CMP_EQ = 2'd0,
    CMP_NE = 2'd1,
    CMP_GT = 2'd2,
    CMP_LT = 2'd3
  } cmp_mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_COMPARE_MODE = 2'd0,
    REG_TARGET_VALUE = 2'd1,
    REG_VALUE_BYTES  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic flush;
  } cell_ctrl_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] address;
    logic [3:0]  len;
  } cmp_result_t;

  // A width of zero counts as one byte, anything above eight as eight.
  function automatic logic [3:0] eff_width(input logic [3:0] vb);
    logic [3:0] w;
    w = vb;
    if (vb == 4'd0) begin
      w = 4'd1;
    end else if (vb > 4'd8) begin
      w = 4'd8;
    end
    return w;
  endfunction

endpackage

// ===== hdl/mvcs_cell.sv =====
module mvcs_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  mvcs_pkg::cell_ctrl_t   ctrl,
  input  logic [7:0]             byte_in,
  input  logic                   valid_in,
  output logic [7:0]             byte_q,
  output logic                   valid_q
);

  // A flush drops the byte handed over by the neighbor, so the window
  // restarts empty at a region boundary.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctrl.shift) begin
      valid_q <= valid_in & ~ctrl.flush;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      byte_q <= ctrl.flush ? 8'd0 : byte_in;
    end
  end

endmodule

// ===== hdl/mvcs_compare.sv =====
module mvcs_compare (
  input  logic [7:0]             win_byte [mvcs_pkg::WinBytes],
  input  logic [7:0]             win_valid,
  input  logic [63:0]            addr,
  input  mvcs_pkg::cmp_mode_t    mode,
  input  logic [63:0]            target_value,
  input  logic [3:0]             value_bytes,
  output mvcs_pkg::cmp_result_t  result
);

  logic [3:0]  w;
  logic [2:0]  sh;
  logic [2:0]  idx [mvcs_pkg::WinBytes];
  logic [63:0] val;
  logic [63:0] tgt;
  logic        enough;
  logic        hit;

  assign w  = mvcs_pkg::eff_width(value_bytes);
  assign sh = 3'(4'd8 - w);

  // The newest w bytes sit in the top cells; the oldest of them is the
  // least significant byte of the value.
  always_comb begin
    for (int k = 0; k < mvcs_pkg::WinBytes; k++) begin
      idx[k] = sh + 3'(k);
      if (4'(k) < w) begin
        val[8*k +: 8] = win_byte[idx[k]];
        tgt[8*k +: 8] = target_value[8*k +: 8];
      end else begin
        val[8*k +: 8] = 8'd0;
        tgt[8*k +: 8] = 8'd0;
      end
    end
  end

  // The cell at the window's start is valid once the region holds w bytes.
  assign enough = win_valid[sh];

  always_comb begin
    unique case (mode)
      mvcs_pkg::CMP_EQ: hit = (val == tgt);
      mvcs_pkg::CMP_NE: hit = (val != tgt);
      mvcs_pkg::CMP_GT: hit = (val > tgt);
      mvcs_pkg::CMP_LT: hit = (val < tgt);
      default:          hit = 1'b0;
    endcase
  end

  assign result.hit     = enough & hit;
  assign result.address = addr - 64'(w - 4'd1);
  assign result.len     = w;

endmodule

// ===== hdl/memory_value_compare_scanner.sv =====
// Memory value compare scanner.
// Input channel (in_valid/in_ready) carries one memory byte per item; an item
// with region_first set starts a new region at address region_base, other
// items continue at the next address. Eight byte cells form a shift window.
// Once the region holds value_bytes bytes, the newest bytes are read
// little-endian and compared with target_value under compare_mode.
// Output channel (out_valid/out_ready) carries one item per hit: the address
// of the window's first byte and the width. Items without a hit give nothing.
// Accepted items shift into the cells; a hit goes to the output register.
// Throughput is one item per cycle unless in_ready is low, set by the cell
// shift and the single 64-bit comparator stage behind it.
// When the receiver stalls, the output register holds its item; the compare
// stage behind it keeps taking items until a second hit is waiting, then
// in_ready drops.
// Reset clears the window, the address, the pipeline valids and the registers
// to compare_mode 0, target_value 0, value_bytes 4. The user must write the
// configuration port only while no item is in flight; it is not enforced.
module memory_value_compare_scanner (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mvcs_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    data_byte,
  input  logic                          region_first,
  input  logic [63:0]                   region_base,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [63:0]                   hit_address,
  output logic [3:0]                    match_len
);

  mvcs_pkg::cmp_mode_t   compare_mode;
  logic [63:0]           target_value;
  logic [3:0]            value_bytes;

  logic [63:0]           next_address;
  logic [63:0]           addr_cur;
  logic                  s1_valid;
  logic [63:0]           s1_addr;
  logic                  accept;
  logic                  out_free;

  logic [7:0]            win_byte [mvcs_pkg::WinBytes];
  logic [7:0]            win_valid;
  mvcs_pkg::cmp_result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_mode <= mvcs_pkg::CMP_EQ;
      target_value <= 64'd0;
      value_bytes  <= 4'd4;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mvcs_pkg::REG_COMPARE_MODE: compare_mode <= mvcs_pkg::cmp_mode_t'(cfg_data[1:0]);
        mvcs_pkg::REG_TARGET_VALUE: target_value <= cfg_data;
        mvcs_pkg::REG_VALUE_BYTES:  value_bytes  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign out_free = ~out_valid | out_ready;
  assign in_ready = ~rst & (~s1_valid | ~res.hit | out_free);
  assign accept   = in_valid & in_ready;
  assign addr_cur = region_first ? region_base : next_address;

  for (genvar i = 0; i < mvcs_pkg::WinBytes; i++) begin : g_win
    mvcs_pkg::cell_ctrl_t ctrl;
    if (i == mvcs_pkg::WinBytes - 1) begin : g_head
      assign ctrl.shift = accept;
      assign ctrl.flush = 1'b0;
      mvcs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (data_byte),
        .valid_in (1'b1),
        .byte_q   (win_byte[i]),
        .valid_q  (win_valid[i])
      );
    end else begin : g_body
      assign ctrl.shift = accept;
      assign ctrl.flush = region_first;
      mvcs_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .byte_in  (win_byte[i+1]),
        .valid_in (win_valid[i+1]),
        .byte_q   (win_byte[i]),
        .valid_q  (win_valid[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_address <= 64'd0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        next_address <= addr_cur + 64'd1;
      end
      if (in_ready) begin
        s1_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr <= addr_cur;
    end
  end

  mvcs_compare u_compare (
    .win_byte     (win_byte),
    .win_valid    (win_valid),
    .addr         (s1_addr),
    .mode         (compare_mode),
    .target_value (target_value),
    .value_bytes  (value_bytes),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid & res.hit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid && res.hit) begin
      hit_address <= res.address;
      match_len   <= res.len;
    end
  end

endmodule

// ===== hdl/mvcs_checker.sv =====
module mvcs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write,
  input logic [mvcs_pkg::CfgIdxW-1:0]  cfg_index,
  input logic [63:0]                   cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [7:0]                    data_byte,
  input logic                          region_first,
  input logic [63:0]                   region_base,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [63:0]                   hit_address,
  input logic [3:0]                    match_len
);

  // A stalled result item keeps its place.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(hit_address) && $stable(match_len))
    else $error("result item changed while stalled");

  // Every width reported is a legal one, whatever was written to the register.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (match_len >= 4'd1 && match_len <= 4'd8))
    else $error("match length out of range");

  // A new result appears only after an input item was taken.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result item without an input item");

endmodule

bind memory_value_compare_scanner mvcs_checker u_mvcs_checker (.*);

// ===== tb/scan_hit_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels and the register port, predicts which accepted bytes
// complete a matching window and checks each hit item against that list.
module scan_hit_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [mvcs_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0]                  cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   data_byte,
  input  logic                         region_first,
  input  logic [63:0]                  region_base,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [63:0]                  hit_address,
  input  logic [3:0]                   match_len,
  output int                           pending,
  output int                           mismatches
);

  mvcs_pkg::cmp_mode_t   mode;
  logic [63:0]           target;
  logic [3:0]            vbytes;
  logic [63:0]           window;
  logic [3:0]            region_count;
  logic [63:0]           next_addr;
  mvcs_pkg::cmp_result_t expected_hits[$];
  int                    fail_count = 0;

  assign mismatches = fail_count;

  task automatic report_mismatch(input string what);
    $display("%0t scan check: %s", $time, what);
    fail_count++;
  endtask

  // Advances the window by one byte and tells whether the newest window hits.
  function automatic mvcs_pkg::cmp_result_t scan_byte(input logic [7:0] b,
                                                      input logic first,
                                                      input logic [63:0] base);
    logic [3:0]            w;
    logic [63:0]           val;
    logic [63:0]           mask;
    logic [63:0]           tgt;
    mvcs_pkg::cmp_result_t r;
    w = (vbytes == 4'd0) ? 4'd1 : ((vbytes > 4'd8) ? 4'd8 : vbytes);
    if (first) begin
      next_addr = base;
      region_count = 4'd0;
      window = 64'd0;
    end
    r.address = next_addr;
    r.len = w;
    r.hit = 1'b0;
    next_addr = next_addr + 64'd1;
    window = {b, window[63:8]};
    if (region_count < 4'd8) begin
      region_count = region_count + 4'd1;
    end
    if (region_count >= w) begin
      val = window >> (8 * (8 - int'(w)));
      mask = (w == 4'd8) ? '1 : ((64'd1 << (8 * int'(w))) - 64'd1);
      tgt = target & mask;
      case (mode)
        mvcs_pkg::CMP_EQ: r.hit = (val == tgt);
        mvcs_pkg::CMP_NE: r.hit = (val != tgt);
        mvcs_pkg::CMP_GT: r.hit = (val > tgt);
        default: r.hit = (val < tgt);
      endcase
      r.address = r.address - 64'(w - 4'd1);
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mvcs_pkg::cmp_result_t predicted;
    mvcs_pkg::cmp_result_t oldest;
    if (rst) begin
      mode = mvcs_pkg::CMP_EQ;
      target = 64'd0;
      vbytes = 4'd4;
      window = 64'd0;
      region_count = 4'd0;
      next_addr = 64'd0;
      expected_hits.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          mvcs_pkg::REG_COMPARE_MODE: mode = mvcs_pkg::cmp_mode_t'(cfg_data[1:0]);
          mvcs_pkg::REG_TARGET_VALUE: target = cfg_data;
          mvcs_pkg::REG_VALUE_BYTES:  vbytes = cfg_data[3:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("hit at %h len %0d with none expected",
                                    hit_address, match_len));
        end else begin
          oldest = expected_hits.pop_front();
          if (hit_address !== oldest.address) begin
            report_mismatch($sformatf("hit_address %h, expected %h",
                                      hit_address, oldest.address));
          end
          if (match_len !== oldest.len) begin
            report_mismatch($sformatf("match_len %0d, expected %0d",
                                      match_len, oldest.len));
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = scan_byte(data_byte, region_first, region_base);
        if (predicted.hit) begin
          expected_hits.push_back(predicted);
        end
      end
    end
    // Registered so the stimulus side always sees the count as of the last edge.
    pending <= expected_hits.size();
  end

endmodule

// ===== tb/memory_value_compare_scanner_test.sv =====
`timescale 1ns / 100ps

module memory_value_compare_scanner_test;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_write = 1'b0;
  logic [mvcs_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [63:0]                   cfg_data = 64'd0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    data_byte = 8'd0;
  logic                          region_first = 1'b0;
  logic [63:0]                   region_base = 64'd0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [63:0]                   hit_address;
  logic [3:0]                    match_len;
  int                            pending;
  int                            mismatches;

  logic                          send_gaps = 1'b0;
  logic                          recv_gaps = 1'b0;
  int                            stall_left = 0;
  logic [63:0]                   cur_target = 64'd0;
  logic [3:0]                    cur_vbytes = 4'd4;

  memory_value_compare_scanner dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .region_first(region_first), .region_base(region_base),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit_address(hit_address), .match_len(match_len)
  );

  scan_hit_checker hit_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .region_first(region_first), .region_base(region_base),
    .out_valid(out_valid), .out_ready(out_ready),
    .hit_address(hit_address), .match_len(match_len),
    .pending(pending), .mismatches(mismatches)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver backpressure in bursts of random length.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    #2_000_000;
    $display("[memory_value_compare_scanner] ERROR");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b, input logic first, input logic [63:0] base);
    if (send_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    region_first <= first;
    region_base <= base;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_hits(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_config(input mvcs_pkg::cmp_mode_t m, input logic [63:0] tgt,
                             input logic [3:0] vb);
    // Bytes that give no hit may still sit in the pipeline after the last hit.
    drain_hits(6);
    cfg_write <= 1'b1;
    cfg_index <= mvcs_pkg::REG_COMPARE_MODE;
    cfg_data <= 64'(m);
    @(posedge clk);
    cfg_index <= mvcs_pkg::REG_TARGET_VALUE;
    cfg_data <= tgt;
    @(posedge clk);
    cfg_index <= mvcs_pkg::REG_VALUE_BYTES;
    cfg_data <= 64'(vb);
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_target = tgt;
    cur_vbytes = vb;
  endtask

  // Random bytes with the target's own bytes planted in order now and then,
  // so that equality windows actually occur.
  task automatic scan_region_mix(input int count);
    int          w;
    int          plant_left;
    logic [7:0]  b;
    logic        first;
    logic [63:0] base;
    w = (cur_vbytes == 4'd0) ? 1 : ((cur_vbytes > 4'd8) ? 8 : int'(cur_vbytes));
    plant_left = 0;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        drain_hits(0);
      end
      first = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 3) == 0) begin
        base = ~64'($urandom_range(0, 12));
      end else begin
        base = {$urandom, $urandom};
      end
      if (plant_left == 0 && $urandom_range(0, 4) == 0) begin
        plant_left = w;
      end
      if (plant_left != 0) begin
        b = cur_target[8 * (w - plant_left) +: 8];
        plant_left--;
      end else begin
        case ($urandom_range(0, 3))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom);
        endcase
      end
      push_byte(b, first, base);
    end
  endtask

  initial begin
    mvcs_pkg::cmp_mode_t m;
    logic [63:0]         tgt;
    logic [3:0]          vb;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: equal to zero over four bytes. Bytes before any region
    // mark count from address zero.
    repeat (5) push_byte(8'h00, 1'b0, '1);
    // A region close to the top of the address space wraps around.
    push_byte(8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
    repeat (4) push_byte(8'h00, 1'b0, 64'd0);
    // A short region ends before a full window.
    push_byte(8'h00, 1'b1, 64'h0000_0000_0000_1000);
    push_byte(8'h00, 1'b0, 64'd0);
    push_byte(8'hFF, 1'b1, '1);
    repeat (3) push_byte(8'hFF, 1'b0, 64'd0);
    push_byte(8'h00, 1'b1, 64'h5555_AAAA_5555_AAAA);
    repeat (4) push_byte(8'h00, 1'b0, 64'hAAAA_5555_AAAA_5555);

    send_gaps = 1'b1;
    recv_gaps <= 1'b1;
    load_config(mvcs_pkg::CMP_EQ, '1, 4'd8);
    scan_region_mix(50);
    load_config(mvcs_pkg::CMP_GT, 64'd0, 4'd0);
    scan_region_mix(50);
    load_config(mvcs_pkg::CMP_LT, '1, 4'd15);
    scan_region_mix(50);
    load_config(mvcs_pkg::CMP_NE, {$urandom, $urandom}, 4'd9);
    scan_region_mix(50);

    for (int p = 0; p < 7; p++) begin
      m = mvcs_pkg::cmp_mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 4))
        0: tgt = 64'd0;
        1: tgt = '1;
        2: tgt = 64'($urandom_range(0, 255));
        default: tgt = {$urandom, $urandom};
      endcase
      if ($urandom_range(0, 3) == 0) begin
        vb = 4'($urandom_range(0, 15));
      end else begin
        vb = 4'($urandom_range(1, 8));
      end
      load_config(m, tgt, vb);
      if (p < 5) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        recv_gaps <= ($urandom_range(0, 3) != 0);
      end else begin
        send_gaps = 1'b0;
        recv_gaps <= 1'b0;
      end
      scan_region_mix(50);
    end

    drain_hits(10);
    if (mismatches == 0 && pending == 0) begin
      $display("[memory_value_compare_scanner] OK");
    end else begin
      $display("[memory_value_compare_scanner] ERROR");
    end
    $finish;
  end

endmodule
